// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define PIP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Types, constants and helpers of the prefix instruction processor core.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Word memory size; must be a power of two so that wrapping is a mask.
  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned STREAM_W = 4;

  localparam logic [WORD_W-1:0] NFIX_MASK = 32'hFFFF_FF00;

  typedef enum logic [3:0] {
    OP_LDAM = 4'h0,
    OP_LDBM = 4'h1,
    OP_STAM = 4'h2,
    OP_LDAC = 4'h3,
    OP_LDBC = 4'h4,
    OP_LDAP = 4'h5,
    OP_LDAI = 4'h6,
    OP_LDBI = 4'h7,
    OP_STAI = 4'h8,
    OP_BR   = 4'h9,
    OP_BRZ  = 4'hA,
    OP_BRN  = 4'hB,
    OP_NOPC = 4'hC,
    OP_OPR  = 4'hD,
    OP_PFIX = 4'hE,
    OP_NFIX = 4'hF
  } opcode_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE = 2'd0,
    EV_OUT  = 2'd1,
    EV_IN   = 2'd2,
    EV_HALT = 2'd3
  } event_e;

  // Operand values selecting an operate-group function.
  localparam logic [WORD_W-1:0] OPR_BRB = 32'd0;
  localparam logic [WORD_W-1:0] OPR_ADD = 32'd1;
  localparam logic [WORD_W-1:0] OPR_SUB = 32'd2;
  localparam logic [WORD_W-1:0] OPR_SVC = 32'd3;

  // Accumulator values selecting a service call.
  localparam logic [WORD_W-1:0] SVC_HALT = 32'd0;
  localparam logic [WORD_W-1:0] SVC_PUT  = 32'd1;
  localparam logic [WORD_W-1:0] SVC_GET  = 32'd2;

  // Word address of the service frame pointer.
  localparam logic [WORD_W-1:0] FRAME_PTR_ADDR = 32'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD_A,
    S_LOAD_B,
    S_SVC_SP,
    S_SVC_OUT,
    S_SVC_STREAM,
    S_SVC_IN
  } state_e;

  // Word address wrapped to the memory size.
  function automatic logic [MEM_AW-1:0] mem_index(input logic [WORD_W-1:0] a);
    return a[MEM_AW-1:0];
  endfunction

  // Console is stream 0; other streams are 1 plus bits 10..8 of the word.
  function automatic logic [STREAM_W-1:0] stream_code(input logic [WORD_W-1:0] s);
    logic [STREAM_W-1:0] code;
    if (s[WORD_W-1:8] == '0) begin
      code = '0;
    end else begin
      code = {1'b0, s[10:8]} + STREAM_W'(1);
    end
    return code;
  endfunction

endpackage

// File: rtl/core/pip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/prefix_instruction_processor_step_core.sv
`timescale 1ns / 1ps
// Steps: a memory write or a halted execute is done in the idle state; an executed
// instruction is fetched, decoded, then takes up to three more memory accesses.
// A new transaction starts only once the last one has finished; the single port
// of the word memory takes at most one access per cycle.
// Reset (rst_ni low, asynchronous) clears pc, A, B, operand, sp and the handshake
// state and sets the machine running; the word memory is not cleared.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// prefix_instruction_processor_step_core
// Accumulator processor with 4-bit prefix operands, one transaction per step.
// ----------------------------------------------------------------------------
module prefix_instruction_processor_step_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [pip_pkg::ADDR_W-1:0]     addr_i,
  input  logic [pip_pkg::WORD_W-1:0]     wdata_i,
  input  logic [pip_pkg::BYTE_W-1:0]     in_byte_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pip_pkg::EVENT_W-1:0]    event_res_o,
  output logic [pip_pkg::BYTE_W-1:0]     out_byte_o,
  output logic [pip_pkg::STREAM_W-1:0]   io_stream_o,
  output logic [pip_pkg::WORD_W-1:0]     pc_now_o,
  output logic [pip_pkg::WORD_W-1:0]     acc_now_o
);
  import pip_pkg::*;

  // --------------------------------------------------------------------------
  // Input buffer. One transaction is held here while the previous one is
  // still being executed, so the input side does not wait on the sequencer.
  // --------------------------------------------------------------------------
  logic                buf_valid_q, buf_valid_d;
  logic                buf_cmd_q;
  logic [ADDR_W-1:0]   buf_addr_q;
  logic [WORD_W-1:0]   buf_wdata_q;
  logic [BYTE_W-1:0]   buf_byte_q;
  logic                in_fire;
  logic                start;

  // Architectural state.
  logic [WORD_W-1:0] pc_q, pc_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;
  logic [WORD_W-1:0] opr_q, opr_d;
  logic [WORD_W-1:0] sp_q, sp_d;
  logic              run_q, run_d;

  // Sequencer working registers.
  state_e            state_q, state_d;
  logic [BYTE_W-1:0] inb_q, ob_q, ob_d;

  // Output register, which frees the sequencer as soon as a result is made.
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                finish;
  event_e              ev_d;
  logic [BYTE_W-1:0]   res_byte_d;
  logic [STREAM_W-1:0] res_stream_d;
  logic [EVENT_W-1:0]  ev_q;
  logic [BYTE_W-1:0]   res_byte_q;
  logic [STREAM_W-1:0] res_stream_q;
  logic [WORD_W-1:0]   res_pc_q, res_acc_q;

  // Memory port.
  logic              ram_en, ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Decode helpers.
  logic [BYTE_W-1:0] inst;
  opcode_e           opc;
  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] pc_inc;
  logic [WORD_W-1:0] pc_rel;
  logic [WORD_W-1:0] ea_base;
  logic [WORD_W-1:0] ea;

  // A new item may start only when its result is sure to find the output
  // register free; with one item in flight, that slot then stays free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign start      = (state_q == S_IDLE) && buf_valid_q && out_free;
  assign in_ready_o = !buf_valid_q || start;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    buf_valid_d = buf_valid_q;
    if (in_fire) begin
      buf_valid_d = 1'b1;
    end else if (start) begin
      buf_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else begin
      buf_valid_q <= buf_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_cmd_q   <= cmd_i;
      buf_addr_q  <= addr_i;
      buf_wdata_q <= wdata_i;
      buf_byte_q  <= in_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Word memory.
  // --------------------------------------------------------------------------
  pip_ram #(
    .Width (WORD_W),
    .Depth (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Decode. The fetched word is in the RAM output register during S_DECODE,
  // and pc still points at the fetched byte.
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (pc_q[1:0])
      2'd0: inst = ram_rdata[7:0];
      2'd1: inst = ram_rdata[15:8];
      2'd2: inst = ram_rdata[23:16];
      2'd3: inst = ram_rdata[31:24];
      default: inst = ram_rdata[7:0];
    endcase
  end

  assign opc     = opcode_e'(inst[7:4]);
  assign operand = opr_q | {{(WORD_W-4){1'b0}}, inst[3:0]};
  assign pc_inc  = pc_q + WORD_W'(1);
  assign pc_rel  = pc_inc + operand;

  // Indexed accesses add a base register to the operand; direct ones use it alone.
  always_comb begin
    unique case (opc)
      OP_LDAI:          ea_base = a_q;
      OP_LDBI, OP_STAI: ea_base = b_q;
      default:          ea_base = '0;
    endcase
  end
  assign ea = ea_base + operand;

  // --------------------------------------------------------------------------
  // Sequencer: next state, memory requests and result.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    a_d          = a_q;
    b_d          = b_q;
    opr_d        = opr_q;
    sp_d         = sp_q;
    run_d        = run_q;
    ob_d         = ob_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = '0;
    ram_wdata    = '0;
    finish       = 1'b0;
    ev_d         = EV_NONE;
    res_byte_d   = '0;
    res_stream_d = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (!buf_cmd_q) begin
            // Program loading is allowed even while halted.
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = mem_index(WORD_W'(buf_addr_q));
            ram_wdata = buf_wdata_q;
            finish    = 1'b1;
          end else if (!run_q) begin
            ev_d   = EV_HALT;
            finish = 1'b1;
          end else begin
            ram_en   = 1'b1;
            ram_addr = mem_index({2'b00, pc_q[WORD_W-1:2]});
            state_d  = S_DECODE;
          end
        end
      end

      S_DECODE: begin
        pc_d  = pc_inc;
        opr_d = '0;
        unique case (opc)
          OP_LDAM, OP_LDAI: begin
            ram_en   = 1'b1;
            ram_addr = mem_index(ea);
            state_d  = S_LOAD_A;
          end
          OP_LDBM, OP_LDBI: begin
            ram_en   = 1'b1;
            ram_addr = mem_index(ea);
            state_d  = S_LOAD_B;
          end
          OP_STAM, OP_STAI: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = mem_index(ea);
            ram_wdata = a_q;
            finish    = 1'b1;
          end
          OP_LDAC: begin
            a_d    = operand;
            finish = 1'b1;
          end
          OP_LDBC: begin
            b_d    = operand;
            finish = 1'b1;
          end
          OP_LDAP: begin
            a_d    = pc_rel;
            finish = 1'b1;
          end
          OP_BR: begin
            pc_d   = pc_rel;
            finish = 1'b1;
          end
          OP_BRZ: begin
            if (a_q == '0) begin
              pc_d = pc_rel;
            end
            finish = 1'b1;
          end
          OP_BRN: begin
            if (a_q[WORD_W-1]) begin
              pc_d = pc_rel;
            end
            finish = 1'b1;
          end
          OP_NOPC: begin
            // Only the operand nibble is merged; the operand is kept.
            opr_d  = operand;
            finish = 1'b1;
          end
          OP_OPR: begin
            finish = 1'b1;
            unique case (operand)
              OPR_BRB: pc_d = b_q;
              OPR_ADD: a_d  = a_q + b_q;
              OPR_SUB: a_d  = a_q - b_q;
              OPR_SVC: begin
                ram_en   = 1'b1;
                ram_addr = mem_index(FRAME_PTR_ADDR);
                state_d  = S_SVC_SP;
                finish   = 1'b0;
              end
              default: ;
            endcase
          end
          OP_PFIX: begin
            opr_d  = operand << 4;
            finish = 1'b1;
          end
          OP_NFIX: begin
            opr_d  = NFIX_MASK | (operand << 4);
            finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
      end

      S_LOAD_A: begin
        a_d    = ram_rdata;
        finish = 1'b1;
      end

      S_LOAD_B: begin
        b_d    = ram_rdata;
        finish = 1'b1;
      end

      S_SVC_SP: begin
        sp_d = ram_rdata;
        unique case (a_q)
          SVC_HALT: begin
            run_d  = 1'b0;
            ev_d   = EV_HALT;
            finish = 1'b1;
          end
          SVC_PUT: begin
            ram_en   = 1'b1;
            ram_addr = mem_index(ram_rdata + WORD_W'(1));
            state_d  = S_SVC_OUT;
          end
          SVC_GET: begin
            ram_en   = 1'b1;
            ram_addr = mem_index(ram_rdata + WORD_W'(1));
            state_d  = S_SVC_IN;
          end
          default: finish = 1'b1;
        endcase
      end

      S_SVC_OUT: begin
        ob_d     = ram_rdata[BYTE_W-1:0];
        ram_en   = 1'b1;
        ram_addr = mem_index(sp_q + WORD_W'(2));
        state_d  = S_SVC_STREAM;
      end

      S_SVC_STREAM: begin
        ev_d         = EV_OUT;
        res_byte_d   = ob_q;
        res_stream_d = stream_code(ram_rdata);
        finish       = 1'b1;
      end

      S_SVC_IN: begin
        // The stream word is read before the input byte overwrites it.
        ev_d         = EV_IN;
        res_stream_d = stream_code(ram_rdata);
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        ram_addr     = mem_index(sp_q + WORD_W'(1));
        ram_wdata    = {{(WORD_W-BYTE_W){1'b0}}, inb_q};
        finish       = 1'b1;
      end

      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      opr_q   <= '0;
      sp_q    <= '0;
      run_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      a_q     <= a_d;
      b_q     <= b_d;
      opr_q   <= opr_d;
      sp_q    <= sp_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    if (start) begin
      inb_q <= buf_byte_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      ev_q         <= ev_d;
      res_byte_q   <= res_byte_d;
      res_stream_q <= res_stream_d;
      res_pc_q     <= pc_d;
      res_acc_q    <= a_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign out_byte_o  = res_byte_q;
  assign io_stream_o = res_stream_q;
  assign pc_now_o    = res_pc_q;
  assign acc_now_o   = res_acc_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A finished result must never overwrite one that is still waiting.
  `PIP_ASSERT_NEVER(a_no_result_overrun, finish && out_valid_q && !out_ready_i, "result overrun")
  // Once halted, the program counter no longer moves.
  `PIP_ASSERT(a_halt_freezes_pc, !run_q |=> $stable(pc_q), "pc moved while halted")
  // A halt result carries neither an output byte nor a stream number.
  `PIP_ASSERT(a_halt_clean, (out_valid_o && event_res_o == EV_HALT) |-> (out_byte_o == '0 && io_stream_o == '0), "halt result not clean")
  // The sequencer leaves idle only for a fetch, which reads memory.
  `PIP_ASSERT(a_fetch_reads, (state_q == S_IDLE && state_d == S_DECODE) |-> (ram_en && !ram_we), "fetch without read")

endmodule
